### sv/uvst_pkg.sv
// Shared types and constants for the UV sphere tessellator.
// No dependencies; used by uvst_cordic and uv_sphere_tessellator_top.
`default_nettype none
package uvst_pkg;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_CFG  = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;

	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_QUAD   = 1'b1;

	localparam logic CFG_SECTOR_COUNT = 1'b0;
	localparam logic CFG_STACK_COUNT  = 1'b1;

	localparam logic [14:0] SECTOR_COUNT_RESET = 15'd36;
	localparam logic [14:0] STACK_COUNT_RESET  = 15'd18;

	localparam logic [31:0] CORDIC_ONE_K = 32'd652032874;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic        v;
		logic        cmd;
		logic [1:0]  status;
		logic        top;
		logic        bottom;
		logic [15:0] first;
		logic [15:0] second;
	} side_t;

endpackage
`default_nettype wire

### sv/uvst_div.sv
// Pipelined restoring divider: floor(dividend * 2^32 / divisor), one bit per stage.
// Valid only for dividend <= divisor. No dependencies.
`default_nettype none
module uvst_div (
	input  wire logic        clk,
	input  wire logic [14:0] dividend,
	input  wire logic [14:0] divisor,
	output logic      [32:0] quotient
);

	localparam int NSTEP = 33;

	logic [15:0] rem_s [NSTEP];
	logic [32:0] quo_s [NSTEP];
	logic        ge0;

	assign ge0 = dividend >= divisor;

	always_ff @(posedge clk) begin
		rem_s[0] <= ge0 ? {1'b0, 15'(dividend - divisor)} : {1'b0, dividend};
		quo_s[0] <= {32'd0, ge0};
	end

	for (genvar j = 1; j < NSTEP; j++) begin : g_step
		logic [16:0] trial;
		logic        ge;
		assign trial = {rem_s[j-1], 1'b0};
		assign ge    = trial >= {2'b00, divisor};
		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? 16'(trial - {2'b00, divisor}) : trial[15:0];
			quo_s[j] <= {quo_s[j-1][31:0], ge};
		end
	end

	assign quotient = quo_s[NSTEP-1];

endmodule
`default_nettype wire

### sv/uvst_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit turn phase in Q2.30.
// Depends on uvst_pkg (gain-compensated start value, arctangent table).
`default_nettype none
module uvst_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic        [31:0] phase,
	output logic signed      [33:0] cos_val,
	output logic signed      [33:0] sin_val
);

	logic signed [33:0] x_s [STEPS+1];
	logic signed [33:0] y_s [STEPS+1];
	logic signed [33:0] z_s [STEPS+1];
	logic               neg_s [STEPS+1];

	logic [31:0] p_add;
	logic [31:0] p_fold;
	logic        do_fold;

	assign p_add   = phase + 32'h4000_0000;
	assign do_fold = p_add[31];
	assign p_fold  = do_fold ? phase + 32'h8000_0000 : phase;

	always_ff @(posedge clk) begin
		x_s[0]   <= $signed({2'b00, uvst_pkg::CORDIC_ONE_K});
		y_s[0]   <= '0;
		z_s[0]   <= $signed({{2{p_fold[31]}}, p_fold});
		neg_s[0] <= do_fold;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] ang;
		assign dx  = x_s[i] >>> i;
		assign dy  = y_s[i] >>> i;
		assign ang = $signed({2'b00, uvst_pkg::ATAN_TURNS[i]});
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - dy;
				y_s[i+1] <= y_s[i] + dx;
				z_s[i+1] <= z_s[i] - ang;
			end else begin
				x_s[i+1] <= x_s[i] + dy;
				y_s[i+1] <= y_s[i] - dx;
				z_s[i+1] <= z_s[i] + ang;
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	always_ff @(posedge clk) begin
		cos_val <= neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		sin_val <= neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	end

endmodule
`default_nettype wire

### sv/uv_sphere_tessellator_top.sv
// UV sphere tessellator: vertex and quad-triangle commands on a fixed-latency pipeline.
// The path from accepted start to strobe runs through the input registers, the 33-stage
// dividers, the CORDIC stages, the multiply and output registers.
// Throughput: one command per cycle while busy is low; a quad with two triangles holds busy for one cycle.
// Second triangle strobes in the cycle after the first; receiver cannot stall.
// Reset: arst_n clears valid bits and loads sector_count 36, stack_count 18.
`default_nettype none
module uv_sphere_tessellator_top #(
	parameter int FRAC_BITS    = 15,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic        [14:0] stack_index,
	input  wire logic        [14:0] sector_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic        [14:0] cfg_data,
	output logic                    strobe,
	output logic             [1:0]  status,
	output logic signed      [15:0] pos_x,
	output logic signed      [15:0] pos_y,
	output logic signed      [15:0] pos_z,
	output logic             [16:0] tex_u,
	output logic             [16:0] tex_v,
	output logic             [15:0] corner_a,
	output logic             [15:0] corner_b,
	output logic             [15:0] corner_c,
	output logic                    last
);

	localparam int DIV_LAT    = 33;
	localparam int SIDE_LEN   = DIV_LAT + CORDIC_STEPS + 3;
	localparam int TEX_LEN    = CORDIC_STEPS + 3;
	localparam int PROD_SHIFT = 61 - FRAC_BITS;
	localparam int Z_SHIFT    = 31 - FRAC_BITS;

	function automatic logic [15:0] sat16(input logic signed [68:0] v);
		if (v > 69'sd32767)
			return 16'h7FFF;
		else if (v < -69'sd32768)
			return 16'h8000;
		else
			return v[15:0];
	endfunction

	logic [14:0] sector_count_q;
	logic [14:0] stack_count_q;
	logic        bubble_q;

	assign cfg_ready = 1'b1;
	assign busy      = bubble_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= uvst_pkg::SECTOR_COUNT_RESET;
			stack_count_q  <= uvst_pkg::STACK_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uvst_pkg::CFG_SECTOR_COUNT: sector_count_q <= cfg_data;
				uvst_pkg::CFG_STACK_COUNT:  stack_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        accept;
	logic        v_s1;
	logic        cmd_s1;
	logic [14:0] st_s1;
	logic [14:0] se_s1;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			bubble_q <= 1'b0;
		end else begin
			v_s1     <= accept;
			bubble_q <= accept && (command == uvst_pkg::CMD_QUAD) && (stack_index != 15'd0)
				&& (({1'b0, stack_index} + 16'd1) != {1'b0, stack_count_q});
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= command;
		st_s1  <= stack_index;
		se_s1  <= sector_index;
	end

	logic [15:0]     sc1;
	logic [15:0]     kc1;
	logic [31:0]     size_prod;
	logic [31:0]     row_base;
	logic            bad_cfg;
	logic            outside;
	uvst_pkg::side_t side_d;

	assign sc1       = {1'b0, sector_count_q} + 16'd1;
	assign kc1       = {1'b0, stack_count_q} + 16'd1;
	assign size_prod = 32'(sc1) * 32'(kc1);
	assign row_base  = 32'({1'b0, st_s1}) * 32'(sc1);
	assign bad_cfg   = (sector_count_q < 15'd3) || (stack_count_q < 15'd2)
		|| (size_prod > 32'd65536);
	assign outside   = (cmd_s1 == uvst_pkg::CMD_QUAD)
		? ((st_s1 >= stack_count_q) || (se_s1 >= sector_count_q))
		: ((st_s1 > stack_count_q) || (se_s1 > sector_count_q));

	always_comb begin
		side_d.v      = v_s1;
		side_d.cmd    = cmd_s1;
		side_d.status = bad_cfg ? uvst_pkg::STATUS_BAD_CFG
			: (outside ? uvst_pkg::STATUS_OUTSIDE : uvst_pkg::STATUS_OK);
		side_d.top    = st_s1 == 15'd0;
		side_d.bottom = ({1'b0, st_s1} + 16'd1) == {1'b0, stack_count_q};
		side_d.first  = row_base[15:0] + {1'b0, se_s1};
		side_d.second = row_base[15:0] + {1'b0, se_s1} + sc1;
	end

	uvst_pkg::side_t side_s2 [SIDE_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_LEN; k++)
				side_s2[k].v <= 1'b0;
		end else begin
			side_s2[0] <= side_d;
			for (int k = 1; k < SIDE_LEN; k++)
				side_s2[k] <= side_s2[k-1];
		end
	end

	logic [32:0] q_se;
	logic [32:0] q_st;

	uvst_div u_div_se (
		.clk      (clk),
		.dividend (se_s1),
		.divisor  (sector_count_q),
		.quotient (q_se)
	);

	uvst_div u_div_st (
		.clk      (clk),
		.dividend (st_s1),
		.divisor  (stack_count_q),
		.quotient (q_st)
	);

	logic [31:0] phase_se;
	logic [31:0] phase_st;

	assign phase_se = q_se[31:0];
	assign phase_st = 32'h4000_0000 - q_st[32:1];

	logic [16:0] tex_u_s3 [TEX_LEN];
	logic [16:0] tex_v_s3 [TEX_LEN];

	always_ff @(posedge clk) begin
		tex_u_s3[0] <= q_se[32:16];
		tex_v_s3[0] <= q_st[32:16];
		for (int k = 1; k < TEX_LEN; k++) begin
			tex_u_s3[k] <= tex_u_s3[k-1];
			tex_v_s3[k] <= tex_v_s3[k-1];
		end
	end

	logic signed [33:0] cos_st;
	logic signed [33:0] sin_st;
	logic signed [33:0] cos_se;
	logic signed [33:0] sin_se;

	uvst_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_st (
		.clk     (clk),
		.phase   (phase_st),
		.cos_val (cos_st),
		.sin_val (sin_st)
	);

	uvst_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_se (
		.clk     (clk),
		.phase   (phase_se),
		.cos_val (cos_se),
		.sin_val (sin_se)
	);

	logic signed [67:0] prod_x_s4;
	logic signed [67:0] prod_y_s4;
	logic        [15:0] pos_z_s4;
	logic signed [34:0] z_round;

	assign z_round = 35'(sin_st) + (35'sd1 <<< (Z_SHIFT - 1));

	always_ff @(posedge clk) begin
		prod_x_s4 <= 68'(cos_st) * 68'(cos_se);
		prod_y_s4 <= 68'(cos_st) * 68'(sin_se);
		pos_z_s4  <= sat16(69'(z_round >>> Z_SHIFT));
	end

	logic signed [68:0] x_round;
	logic signed [68:0] y_round;
	logic        [15:0] pos_x_d;
	logic        [15:0] pos_y_d;
	uvst_pkg::side_t    side_o;

	assign x_round = 69'(prod_x_s4) + (69'sd1 <<< (PROD_SHIFT - 1));
	assign y_round = 69'(prod_y_s4) + (69'sd1 <<< (PROD_SHIFT - 1));
	assign pos_x_d = sat16(x_round >>> PROD_SHIFT);
	assign pos_y_d = sat16(y_round >>> PROD_SHIFT);
	assign side_o  = side_s2[SIDE_LEN-1];

	logic        strobe_s5;
	logic [1:0]  status_s5;
	logic [15:0] pos_x_s5;
	logic [15:0] pos_y_s5;
	logic [15:0] pos_z_s5;
	logic [16:0] tex_u_s5;
	logic [16:0] tex_v_s5;
	logic [15:0] corner_a_s5;
	logic [15:0] corner_b_s5;
	logic [15:0] corner_c_s5;
	logic        last_s5;
	logic        hold_v_q;
	logic [15:0] hold_a_q;
	logic [15:0] hold_b_q;
	logic [15:0] hold_c_q;

	// second triangle of a quad goes out in the bubble slot that follows it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s5 <= 1'b0;
			hold_v_q  <= 1'b0;
		end else begin
			strobe_s5   <= hold_v_q || side_o.v;
			hold_v_q    <= 1'b0;
			status_s5   <= uvst_pkg::STATUS_OK;
			pos_x_s5    <= '0;
			pos_y_s5    <= '0;
			pos_z_s5    <= '0;
			tex_u_s5    <= '0;
			tex_v_s5    <= '0;
			corner_a_s5 <= '0;
			corner_b_s5 <= '0;
			corner_c_s5 <= '0;
			last_s5     <= 1'b1;
			if (hold_v_q) begin
				corner_a_s5 <= hold_a_q;
				corner_b_s5 <= hold_b_q;
				corner_c_s5 <= hold_c_q;
			end else if (side_o.v) begin
				if (side_o.status != uvst_pkg::STATUS_OK) begin
					status_s5 <= side_o.status;
				end else if (side_o.cmd == uvst_pkg::CMD_VERTEX) begin
					pos_x_s5 <= pos_x_d;
					pos_y_s5 <= pos_y_d;
					pos_z_s5 <= pos_z_s4;
					tex_u_s5 <= tex_u_s3[TEX_LEN-1];
					tex_v_s5 <= tex_v_s3[TEX_LEN-1];
				end else if (!side_o.top) begin
					corner_a_s5 <= side_o.first;
					corner_b_s5 <= side_o.second;
					corner_c_s5 <= side_o.first + 16'd1;
					last_s5     <= side_o.bottom;
					hold_v_q    <= !side_o.bottom;
					hold_a_q    <= side_o.first + 16'd1;
					hold_b_q    <= side_o.second;
					hold_c_q    <= side_o.second + 16'd1;
				end else begin
					corner_a_s5 <= side_o.first + 16'd1;
					corner_b_s5 <= side_o.second;
					corner_c_s5 <= side_o.second + 16'd1;
				end
			end
		end
	end

	assign strobe   = strobe_s5;
	assign status   = status_s5;
	assign pos_x    = pos_x_s5;
	assign pos_y    = pos_y_s5;
	assign pos_z    = pos_z_s5;
	assign tex_u    = tex_u_s5;
	assign tex_v    = tex_v_s5;
	assign corner_a = corner_a_s5;
	assign corner_b = corner_b_s5;
	assign corner_c = corner_c_s5;
	assign last     = last_s5;

`ifndef ASSERT_OFF
	a_hold_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> !side_o.v)
		else $error("pending second triangle collides with a pipeline item");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && last)
		else $error("first triangle not followed by the final one");

	a_bubble_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");
`endif

endmodule
`default_nettype wire

### tb/uv_sphere_tessellator_top_tb.sv
// Self-checking testbench for uv_sphere_tessellator_top: directed table, then random
// vertex/quad commands across several mesh settings, checked against a local predictor.
// Depends on uvst_pkg and uv_sphere_tessellator_top.
`default_nettype none
module uv_sphere_tessellator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam int FRAC  = 15;
	localparam int NROWS = 19;

	typedef struct {
		logic [1:0]         status;
		logic signed [15:0] px, py, pz;
		logic [16:0]        u, v;
		logic [15:0]        a, b, c;
		logic               lst;
	} mesh_res_t;

	typedef struct {
		logic      cmd;
		logic [14:0] st, se;
		int        n;
		mesh_res_t r0, r1;
	} dir_row_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic start = 1'b0, command = 1'b0;
	logic [14:0] stack_index = '0, sector_index = '0;
	logic cfg_valid = 1'b0, cfg_index = 1'b0;
	logic [14:0] cfg_data = '0;
	logic busy, cfg_ready, strobe, last;
	logic [1:0] status;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [16:0] tex_u, tex_v;
	logic [15:0] corner_a, corner_b, corner_c;

	uv_sphere_tessellator_top uut (.*);

	logic [14:0] n_sectors = uvst_pkg::SECTOR_COUNT_RESET;
	logic [14:0] n_stacks = uvst_pkg::STACK_COUNT_RESET;
	mesh_res_t mesh_expected[$];
	dir_row_t rows[NROWS];
	int nrows = 0;
	int errors = 0;
	bit gaps_on = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic mesh_res_t blank(logic [1:0] s, logic l);
		mesh_res_t r;
		r = '{status: s, px: 0, py: 0, pz: 0, u: 0, v: 0, a: 0, b: 0, c: 0, lst: l};
		return r;
	endfunction

	function automatic mesh_res_t make_tri(int a, int b, int c, logic l);
		mesh_res_t r;
		r = blank(uvst_pkg::STATUS_OK, l);
		r.a = a[15:0];
		r.b = b[15:0];
		r.c = c[15:0];
		return r;
	endfunction

	function automatic void queue_expected(mesh_res_t r);
		mesh_expected.insert(mesh_expected.size(), r);
	endfunction

	function automatic void add_row(logic cmd, logic [14:0] st, logic [14:0] se, int n,
		mesh_res_t r0, mesh_res_t r1);
		rows[nrows].cmd = cmd;
		rows[nrows].st = st;
		rows[nrows].se = se;
		rows[nrows].n = n;
		rows[nrows].r0 = r0;
		rows[nrows].r1 = r1;
		nrows++;
	endfunction

	function automatic void sincos(input logic [31:0] phase, output longint cs, output longint sn);
		logic [31:0] p;
		bit neg;
		longint x, y, z, dx, dy;
		p = phase;
		neg = 0;
		if (((p + 32'h40000000) & 32'h80000000) != 0) begin
			p = p + 32'h80000000;
			neg = 1;
		end
		z = longint'($signed(p));
		x = longint'(uvst_pkg::CORDIC_ONE_K);
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(uvst_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(uvst_pkg::ATAN_TURNS[i]);
			end
		end
		cs = neg ? -x : x;
		sn = neg ? -y : y;
	endfunction

	function automatic logic [15:0] round_sat(longint v, int s);
		longint r;
		r = (v + (longint'(1) << (s - 1))) >>> s;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	task automatic tessellate(logic cmd, logic [14:0] st, logic [14:0] se);
		longint unsigned sc, kc, q;
		longint cst, sst, cse, sse;
		logic [31:0] ph_se, ph_st;
		mesh_res_t r;
		int first, second;
		sc = n_sectors;
		kc = n_stacks;
		if (sc < 3 || kc < 2 || (sc + 1) * (kc + 1) > 65536) begin
			queue_expected(blank(uvst_pkg::STATUS_BAD_CFG, 1));
		end else if (cmd == uvst_pkg::CMD_VERTEX) begin
			if (st > kc || se > sc) begin
				queue_expected(blank(uvst_pkg::STATUS_OUTSIDE, 1));
			end else begin
				q = (longint'(se) << 32) / sc;
				ph_se = q[31:0];
				q = (longint'(st) << 31) / kc;
				ph_st = 32'h40000000 - q[31:0];
				sincos(ph_st, cst, sst);
				sincos(ph_se, cse, sse);
				r = blank(uvst_pkg::STATUS_OK, 1);
				r.px = round_sat(cst * cse, 61 - FRAC);
				r.py = round_sat(cst * sse, 61 - FRAC);
				r.pz = round_sat(sst, 31 - FRAC);
				q = (longint'(se) << 16) / sc;
				r.u = q[16:0];
				q = (longint'(st) << 16) / kc;
				r.v = q[16:0];
				queue_expected(r);
			end
		end else begin
			if (st >= kc || se >= sc) begin
				queue_expected(blank(uvst_pkg::STATUS_OUTSIDE, 1));
			end else begin
				first = int'(st) * int'(sc + 1) + int'(se);
				second = first + int'(sc) + 1;
				if (st != 0)
					queue_expected(make_tri(first, second, first + 1, st == kc - 1));
				if (st != kc - 1)
					queue_expected(make_tri(first + 1, second, second + 1, 1));
			end
		end
	endtask

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		mesh_res_t e;
		if (arst_n && strobe) begin
			if (mesh_expected.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				errors++;
			end else begin
				e = mesh_expected.pop_front();
				check_field("status", e.status, status);
				check_field("pos_x", e.px, pos_x);
				check_field("pos_y", e.py, pos_y);
				check_field("pos_z", e.pz, pos_z);
				check_field("tex_u", e.u, tex_u);
				check_field("tex_v", e.v, tex_v);
				check_field("corner_a", e.a, corner_a);
				check_field("corner_b", e.b, corner_b);
				check_field("corner_c", e.c, corner_c);
				check_field("last", e.lst, last);
			end
		end
	end

	// drives one transaction; start stays high into the next call when there is no gap
	task automatic issue(logic cmd, logic [14:0] st, logic [14:0] se, bit predict);
		if (gaps_on && $urandom_range(0, 99) < 29) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		stack_index <= st;
		sector_index <= se;
		do @(posedge clk); while (busy);
		if (predict)
			tessellate(cmd, st, se);
	endtask

	task automatic write_reg(logic idx, logic [14:0] val);
		repeat ($urandom_range(0, 3)) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == uvst_pkg::CFG_SECTOR_COUNT)
			n_sectors = val;
		else
			n_stacks = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain(int limit);
		int k;
		k = 0;
		while (mesh_expected.size() != 0 && k < limit) begin
			@(posedge clk);
			k++;
		end
		repeat (70) @(posedge clk);
	endtask

	initial begin
		int sc_list[11] = '{3, 255, 21844, 3, 0, 2, 5, 32767, 256, 36, 100};
		int kc_list[11] = '{2, 255, 2, 16383, 0, 21844, 1, 32767, 255, 18, 50};
		int quota;
		logic cmd;
		logic [14:0] st, se;

		add_row(uvst_pkg::CMD_VERTEX, 15'd0, 15'd0, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd18, 15'd36, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd18, 15'd0, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd0, 15'd36, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd9, 15'd9, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd9, 15'd27, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd4, 15'd18, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd19, 15'd0, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'd0, 15'd37, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_VERTEX, 15'h7FFF, 15'h7FFF, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd18, 15'd0, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd0, 15'd36, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'h7FFF, 15'h7FFF, 1,
			blank(uvst_pkg::STATUS_OUTSIDE, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd0, 15'd0, 1, make_tri(1, 37, 38, 1), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd17, 15'd0, 1, make_tri(629, 666, 630, 1),
			blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd1, 15'd0, 2, make_tri(37, 74, 38, 0),
			make_tri(38, 74, 75, 1));
		add_row(uvst_pkg::CMD_QUAD, 15'd16, 15'd35, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd0, 15'd35, 0, blank(0, 0), blank(0, 0));
		add_row(uvst_pkg::CMD_QUAD, 15'd17, 15'd35, 0, blank(0, 0), blank(0, 0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < nrows; i++) begin
			issue(rows[i].cmd, rows[i].st, rows[i].se, rows[i].n == 0);
			if (rows[i].n > 0) queue_expected(rows[i].r0);
			if (rows[i].n > 1) queue_expected(rows[i].r1);
		end
		@(negedge clk);
		start <= 1'b0;

		foreach (sc_list[p]) begin
			drain(5000);
			if ($urandom_range(0, 1)) begin
				write_reg(uvst_pkg::CFG_SECTOR_COUNT, sc_list[p][14:0]);
				write_reg(uvst_pkg::CFG_STACK_COUNT, kc_list[p][14:0]);
			end else begin
				write_reg(uvst_pkg::CFG_STACK_COUNT, kc_list[p][14:0]);
				write_reg(uvst_pkg::CFG_SECTOR_COUNT, sc_list[p][14:0]);
			end
			quota = (p == 4 || p == 5 || p == 6 || p == 7 || p == 8) ? 40 : 250;
			for (int i = 0; i < quota; i++) begin
				gaps_on = !(p == 1 && i < 150);
				cmd = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 15) begin
					st = 15'($urandom);
					se = 15'($urandom);
				end else begin
					st = 15'($urandom_range(0, n_stacks));
					se = 15'($urandom_range(0, n_sectors));
					if ($urandom_range(0, 9) == 0)
						st = $urandom_range(0, 1) ? 15'd0 : n_stacks;
					if ($urandom_range(0, 9) == 0)
						se = $urandom_range(0, 1) ? 15'd0 : n_sectors;
				end
				issue(cmd, st, se, 1);
			end
			@(negedge clk);
			start <= 1'b0;
		end

		drain(20000);
		if (errors == 0 && mesh_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			foreach (mesh_expected[i])
				if (i < 5) $display("%0t: missing result, status %0d", $time,
					mesh_expected[i].status);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
sv/uvst_pkg.sv
sv/uvst_div.sv
sv/uvst_cordic.sv
sv/uv_sphere_tessellator_top.sv
tb/uv_sphere_tessellator_top_tb.sv
